FILE: design/text_console_char_writer_core_assert.svh
// Assertion macros for the text console character writer
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset
`define TCCW_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, live during reset
`define TCCW_ASSERT_NXT(lbl, clk, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

FILE: design/tccw_pkg.sv
// Shared types, constants and helpers for the text console character writer
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int DEF_SCREEN_COLUMNS = 90;
  localparam int DEF_SCREEN_ROWS    = 30;

  localparam int CODE_W      = 8;
  localparam int INDEX_W     = 12;
  localparam int CELL_W      = 16;
  localparam int POS_W       = 12;
  localparam int COLOUR_W    = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CODE_W-1:0]   NEWLINE_CODE = 8'd10;
  localparam logic [CODE_W-1:0]   SPACE_CODE   = 8'h20;
  localparam logic [CELL_W-1:0]   RESET_CELL   = 16'h0F20;
  localparam logic [COLOUR_W-1:0] RESET_FG     = 4'hF;
  localparam logic [COLOUR_W-1:0] RESET_BG     = 4'h0;

  // Operation field codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'b1;

  typedef enum logic [1:0] {
    CMD_CHAR      = 2'd0,
    CMD_NEWLINE   = 2'd1,
    CMD_READ      = 2'd2,
    CMD_READ_NONE = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CODE_W-1:0]    code;
    logic [INDEX_W-1:0]   index;
  } cmd_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] background;
    logic [COLOUR_W-1:0] foreground;
  } colour_t;

  typedef struct packed {
    logic clearing;
    logic scrolling;
  } status_t;

  function automatic logic [CELL_W-1:0] make_cell(colour_t c, logic [CODE_W-1:0] code);
    return {c.background, c.foreground, code};
  endfunction

endpackage

FILE: design/tccw_channels.sv
// Request and result channel interfaces
`timescale 1ns / 1ps

interface tccw_req_if;
  import tccw_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [CODE_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;
  modport source (output valid, operation, char_code, cell_index, input ready);
  modport sink   (input valid, operation, char_code, cell_index, output ready);
endinterface

interface tccw_rsp_if;
  import tccw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [POS_W-1:0]  cursor_position;
  modport source (output valid, cell_value, cursor_position, input ready);
  modport sink   (input valid, cell_value, cursor_position, output ready);
endinterface

FILE: design/text_console_char_writer_core.sv
// Text console character writer: top level with colour registers
//
// Requests arrive on req: operation 0 puts char_code at the cursor (10 is a
// newline), operation 1 reads the cell at cell_index. Every request gives one
// result on rsp with cell_value and the linear cursor_position.
// Colours are set through cfg_write / cfg_index / cfg_data while idle.
// A put or an out-of-range read passes through the command queue and the
// result register; an in-range read also passes the registered store read.
// Throughput: one put per cycle while rsp.ready is high and no scroll or clear
// runs; an in-range read holds the back end while the store is read. A put that
// finds the cursor below the last row first scrolls the store: rows are copied
// up through the store read and write ports, then the last row is blanked.
// After reset the store is cleared to white spaces, one cell a cycle, with
// req.ready low meanwhile. When the receiver holds rsp.ready low, the result
// register keeps its value and up to two requests still queue before
// req.ready drops.
`timescale 1ns / 1ps

module text_console_char_writer_core #(
  parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                               clk,
  input  logic                               rst,
  tccw_req_if.sink                           req,
  tccw_rsp_if.source                         rsp,
  input  logic                               cfg_write,
  input  logic [tccw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tccw_pkg::COLOUR_W-1:0]      cfg_data
);
  import tccw_pkg::*;

  `include "text_console_char_writer_core_assert.svh"

  colour_t colours;
  status_t status;
  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;

  // Colour registers
  always_ff @(posedge clk) begin
    if (rst) begin
      colours.foreground <= RESET_FG;
      colours.background <= RESET_BG;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FOREGROUND: colours.foreground <= cfg_data;
        CFG_BACKGROUND: colours.background <= cfg_data;
        default:        colours <= colours;
      endcase
    end
  end

  tccw_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .hold      (status.clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tccw_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .colours   (colours),
    .status    (status),
    .rsp       (rsp)
  );

  // Checks
  `TCCW_ASSERT_IMP(a_pop_needs_item, clk, rst, cmd_pop, cmd_valid, "queue popped while empty")
  `TCCW_ASSERT_IMP(a_no_pop_while_busy, clk, rst, status.scrolling || status.clearing, !cmd_pop, "command taken during scroll or clear")
  `TCCW_ASSERT_IMP(a_no_request_while_clearing, clk, rst, status.clearing, !(req.valid && req.ready), "request taken during clear pass")
  `TCCW_ASSERT_NXT(a_reset_starts_clear, clk, rst, status.clearing && !rsp.valid, "reset did not start the clear pass")

endmodule

FILE: design/tccw_front.sv
// Front end: takes requests, classifies them and queues commands for the back end
`timescale 1ns / 1ps

module tccw_front #(
  parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic          clk,
  input  logic          rst,
  tccw_req_if.sink      req,
  input  logic          hold,
  output logic          cmd_valid,
  output tccw_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import tccw_pkg::*;

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  cmd_t             incoming;

  // Classify the request
  always_comb begin
    incoming.code  = req.char_code;
    incoming.index = req.cell_index;
    if (req.operation == OP_READ) begin
      incoming.kind = (32'(req.cell_index) < 32'(CELLS)) ? CMD_READ : CMD_READ_NONE;
    end else begin
      incoming.kind = (req.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_CHAR;
    end
  end

  assign req.ready = (count != CNT_FULL) && !hold;
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/tccw_back.sv
// Back end: cursor, screen store, scroll and clear sequencer, result register
`timescale 1ns / 1ps

module tccw_back #(
  parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  tccw_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  tccw_pkg::colour_t colours,
  output tccw_pkg::status_t status,
  tccw_rsp_if.source        rsp
);
  import tccw_pkg::*;

  localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int LAST   = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(SCREEN_COLUMNS + 1);
  localparam int ROW_W  = $clog2(SCREEN_ROWS + 1);
  localparam int LIN_W  = $clog2(CELLS + SCREEN_COLUMNS + 1);

  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(LAST);
  localparam logic [ADDR_W-1:0] CELLS_M1 = ADDR_W'(CELLS - 1);
  localparam logic [COL_W-1:0]  COLS_C   = COL_W'(SCREEN_COLUMNS);
  localparam logic [ROW_W-1:0]  ROWS_C   = ROW_W'(SCREEN_ROWS);
  localparam logic [ROW_W-1:0]  ROWS_M1  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [LIN_W-1:0]  COLS_L   = LIN_W'(SCREEN_COLUMNS);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_READ  = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_FILL  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [LIN_W-1:0]  lin, lin_next;
  logic              pend_valid, pend_valid_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              out_valid;
  logic [CELL_W-1:0] out_value;
  logic [POS_W-1:0]  out_pos;
  logic              out_load;
  logic              out_free;
  logic [CELL_W-1:0] load_value;
  logic [POS_W-1:0]  load_pos;

  logic              wrap;
  logic [COL_W-1:0]  col_w;
  logic [ROW_W-1:0]  row_w;
  logic              need_scroll;
  logic [CELL_W-1:0] char_cell;

  // Lazy wrap of the cursor ahead of a put
  assign wrap        = (col == COLS_C);
  assign col_w       = wrap ? '0 : col;
  assign row_w       = wrap ? row + 1'b1 : row;
  assign need_scroll = (row_w == ROWS_C);
  assign char_cell   = make_cell(colours, cmd.code);
  assign out_free    = !out_valid || rsp.ready;

  // Sequencer
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    col_next        = col;
    row_next        = row;
    lin_next        = lin;
    pend_valid_next = 1'b0;
    pend_addr_next  = pend_addr;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = RESET_CELL;
    mem_re          = 1'b0;
    mem_raddr       = ADDR_W'(cmd.index);
    cmd_pop         = 1'b0;
    out_load        = 1'b0;
    load_value      = '0;
    load_pos        = POS_W'(lin);
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx == CELLS_M1) begin
          idx_next   = '0;
          state_next = ST_RUN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_RUN: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_READ_NONE: begin
              if (out_free) begin
                cmd_pop  = 1'b1;
                out_load = 1'b1;
              end
            end
            CMD_READ: begin
              if (out_free) begin
                cmd_pop    = 1'b1;
                mem_re     = 1'b1;
                state_next = ST_READ;
              end
            end
            CMD_CHAR, CMD_NEWLINE: begin
              priority if (need_scroll) begin
                // Cursor sits below the last row: move the screen up first
                row_next   = ROWS_M1;
                col_next   = col_w;
                lin_next   = lin - COLS_L;
                idx_next   = '0;
                state_next = ST_COPY;
              end else if (out_free) begin
                cmd_pop  = 1'b1;
                out_load = 1'b1;
                if (cmd.kind == CMD_NEWLINE) begin
                  row_next = row_w + 1'b1;
                  col_next = '0;
                  lin_next = lin - LIN_W'(col_w) + COLS_L;
                end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = ADDR_W'(lin);
                  mem_wdata  = char_cell;
                  load_value = char_cell;
                  row_next   = row_w;
                  col_next   = col_w + 1'b1;
                  lin_next   = lin + 1'b1;
                end
                load_pos = POS_W'(lin_next);
              end else begin
                state_next = ST_RUN;
              end
            end
            default: state_next = ST_RUN;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_value = rd_data;
          state_next = ST_RUN;
        end
      end
      ST_COPY: begin
        // Read one row below, write it back in the next cycle
        mem_we    = pend_valid;
        mem_waddr = pend_addr;
        mem_wdata = rd_data;
        if (idx != LAST_A) begin
          mem_re          = 1'b1;
          mem_raddr       = idx + COLS_A;
          pend_valid_next = 1'b1;
          pend_addr_next  = idx;
          idx_next        = idx + 1'b1;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        // Blank the last row in the current colours
        mem_we    = 1'b1;
        mem_wdata = make_cell(colours, SPACE_CODE);
        if (idx == CELLS_M1) begin
          idx_next   = '0;
          state_next = ST_RUN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      idx        <= '0;
      col        <= '0;
      row        <= '0;
      lin        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      col        <= col_next;
      row        <= row_next;
      lin        <= lin_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_load || (out_valid && !rsp.ready);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    if (out_load) begin
      out_value <= load_value;
      out_pos   <= load_pos;
    end
  end

  // Screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.cell_value      = out_value;
  assign rsp.cursor_position = out_pos;

  assign status.clearing  = (state == ST_CLEAR);
  assign status.scrolling = (state == ST_COPY) || (state == ST_FILL);

endmodule

FILE: test/text_console_char_writer_core_checker.sv
// Checker for the text console writer: predicts each result and compares it
`timescale 1ns / 1ps

module text_console_char_writer_core_checker #(
  parameter int COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  tccw_req_if                              req,
  tccw_rsp_if                              rsp,
  input  logic                             cfg_write,
  input  logic [tccw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tccw_pkg::COLOUR_W-1:0]    cfg_data,
  output int                               mismatches,
  output int                               outstanding
);
  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct {
    logic [CELL_W-1:0] cell_value;
    logic [POS_W-1:0]  cursor_position;
  } console_result_t;

  // Shadow copy of the screen, cursor and colours
  logic [CELL_W-1:0]   screen [CELLS];
  int unsigned         cur_row;
  int unsigned         cur_col;
  logic [COLOUR_W-1:0] fg_colour;
  logic [COLOUR_W-1:0] bg_colour;

  console_result_t expected_results [$];
  int failures = 0;

  // Apply one request to the shadow console and return the result it gives
  function automatic console_result_t predict_console_request(
    logic op, logic [CODE_W-1:0] code, logic [INDEX_W-1:0] index);
    console_result_t res;
    int unsigned     addr;
    int unsigned     last_row_base;
    res.cell_value = '0;
    if (op == OP_READ) begin
      if (index < CELLS) res.cell_value = screen[index];
    end else begin
      // lazy wrap
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      // scroll up one row, blank the bottom row in current colours
      if (cur_row >= ROWS) begin
        last_row_base = (ROWS - 1) * COLUMNS;
        for (int i = 0; i < last_row_base; i++) screen[i] = screen[i + COLUMNS];
        for (int i = 0; i < COLUMNS; i++)
          screen[last_row_base + i] = {bg_colour, fg_colour, SPACE_CODE};
        cur_row = ROWS - 1;
      end
      if (code == NEWLINE_CODE) begin
        cur_row++;
        cur_col = 0;
      end else begin
        res.cell_value = {bg_colour, fg_colour, code};
        addr = cur_row * COLUMNS + cur_col;
        if (addr < CELLS) screen[addr] = res.cell_value;
        cur_col++;
      end
    end
    res.cursor_position = POS_W'(cur_col + cur_row * COLUMNS);
    return res;
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = RESET_CELL;
      cur_row   = 0;
      cur_col   = 0;
      fg_colour = RESET_FG;
      bg_colour = RESET_BG;
      expected_results.delete();
    end else begin
      // colour register writes
      if (cfg_write) begin
        if (cfg_index == CFG_FOREGROUND) fg_colour = cfg_data;
        else if (cfg_index == CFG_BACKGROUND) bg_colour = cfg_data;
      end
      // result side: compare against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: cell_value %h, cursor_position %0d",
                 rsp.cell_value, rsp.cursor_position);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.cell_value !== want.cell_value) begin
            $error("cell_value: expected %h, got %h", want.cell_value, rsp.cell_value);
            failures++;
          end
          if (rsp.cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d",
                   want.cursor_position, rsp.cursor_position);
            failures++;
          end
        end
      end
      // request side: predict
      if (req.valid && req.ready)
        expected_results.push_back(
          predict_console_request(req.operation, req.char_code, req.cell_index));
    end
    mismatches  <= failures;
    outstanding <= expected_results.size();
  end

endmodule

FILE: test/text_console_char_writer_core_tb.sv
// Testbench top for the text console writer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module text_console_char_writer_core_tb;
  import tccw_pkg::*;

  localparam int COLUMNS     = DEF_SCREEN_COLUMNS;
  localparam int ROWS        = DEF_SCREEN_ROWS;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 280;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COLOUR_W-1:0]    cfg_data;
  int                     mismatches;
  int                     outstanding;
  int                     source_idle_pct = 0;
  int                     sink_idle_pct = 0;
  bit                     hold_armed = 1'b0;
  int                     quiet_cycles = 0;

  tccw_req_if req_ch ();
  tccw_rsp_if rsp_ch ();

  text_console_char_writer_core uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  text_console_char_writer_core_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) console_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("text_console_char_writer_core_tb: done, errors");
      $finish;
    end
  end

  // Result receiver: random stalls plus one long hold-off when armed
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offer one request, with random idle cycles first; returns at the accepting edge
  task automatic send_request(logic op, logic [CODE_W-1:0] code, logic [INDEX_W-1:0] index);
    while ($urandom_range(99) < source_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.char_code  <= code;
    req_ch.cell_index <= index;
    // ready is stable between the falling edge and the next rising edge
    do @(negedge clk); while (req_ch.ready !== 1'b1);
    @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic set_colours(logic [COLOUR_W-1:0] fg, logic [COLOUR_W-1:0] bg);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FOREGROUND;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= CFG_BACKGROUND;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly in range, some past the end of the store, some on the bottom row
  function automatic logic [INDEX_W-1:0] pick_read_index();
    case ($urandom_range(9))
      0: return INDEX_W'(CELLS + $urandom_range((1 << INDEX_W) - 1 - CELLS));
      1: return INDEX_W'(CELLS - 1 - $urandom_range(COLUMNS - 1));
      default: return INDEX_W'($urandom_range(CELLS - 1));
    endcase
  endfunction

  // Random console traffic: text lines, newline runs, read-backs and noise
  task automatic run_console_traffic(int count);
    int sent;
    int burst;
    int len;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(99);
      if (burst < 45) begin
        // text line, sometimes longer than the screen to force a wrap
        len = ($urandom_range(9) == 0) ? $urandom_range(85, 120) : $urandom_range(1, 40);
        for (int k = 0; k < len; k++)
          send_request(OP_PUT, CODE_W'($urandom_range(255)), INDEX_W'($urandom_range(4095)));
        sent += len;
        if ($urandom_range(9) < 7) begin
          send_request(OP_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(4095)));
          sent++;
        end
      end else if (burst < 60) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_request(OP_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(4095)));
        sent += len;
      end else if (burst < 85) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_request(OP_READ, CODE_W'($urandom_range(255)), pick_read_index());
        sent += len;
      end else begin
        send_request(logic'($urandom_range(1)), CODE_W'($urandom_range(255)),
                     INDEX_W'($urandom_range(4095)));
        sent++;
      end
    end
  endtask

  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_PUT;
    req_ch.char_code  <= '0;
    req_ch.cell_index <= '0;
    cfg_write         <= 1'b0;
    cfg_index         <= CFG_FOREGROUND;
    cfg_data          <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: store after reset, index extremes, out-of-range reads
    send_request(OP_READ, 8'h00, 12'd0);
    send_request(OP_READ, 8'hFF, INDEX_W'(CELLS - 1));
    send_request(OP_READ, 8'h00, INDEX_W'(CELLS));
    send_request(OP_READ, 8'hFF, 12'hFFF);
    // character extremes, a newline, then read them back
    send_request(OP_PUT, 8'h00, 12'hFFF);
    send_request(OP_PUT, 8'hFF, 12'd0);
    send_request(OP_PUT, 8'h7F, 12'd0);
    send_request(OP_PUT, 8'h80, 12'd0);
    send_request(OP_PUT, NEWLINE_CODE, 12'd0);
    send_request(OP_PUT, 8'h41, 12'd0);
    send_request(OP_READ, 8'h00, 12'd0);
    send_request(OP_READ, 8'h00, 12'd1);
    send_request(OP_READ, 8'h00, 12'd4);
    send_request(OP_READ, 8'h00, INDEX_W'(COLUMNS));
    drain_results();

    // Phase 1: sender mostly busy, receiver mostly stalled
    set_colours(4'h0, 4'hF);
    source_idle_pct = 12;
    sink_idle_pct   = 79;
    run_console_traffic(PHASE_ITEMS);
    drain_results();

    // Phase 2: the other way round
    set_colours(4'hF, 4'h0);
    source_idle_pct = 79;
    sink_idle_pct   = 12;
    run_console_traffic(PHASE_ITEMS);
    drain_results();

    // Phase 3: no idling, opens with a long receiver hold-off
    set_colours(COLOUR_W'($urandom_range(15)), COLOUR_W'($urandom_range(15)));
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    hold_armed      = 1'b1;
    run_console_traffic(PHASE_ITEMS);
    drain_results();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_char_writer_core_tb: done, clean");
    end else begin
      $display("text_console_char_writer_core_tb: done, errors");
    end
    $finish;
  end

endmodule
